/* sv/rle_sprite_priority_blitter_core_assert.svh */
// Assertion macros for the sprite blitter RTL.
// Used by modules that declare clk and rst_n; no other dependencies.
`ifndef RLE_SPRITE_PRIORITY_BLITTER_CORE_ASSERT_SVH
`define RLE_SPRITE_PRIORITY_BLITTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RSPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RSPB_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSPB_ASSERT(lbl, prop, msg)
`define RSPB_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

/* sv/rspb_pkg.sv */
// Shared types and constants for the run-length sprite blitter.
// No dependencies.
package rspb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 160;
  localparam int SCREEN_HEIGHT_DEF = 168;

  // plane word: [3:0] screen priority, [7:4] picture colour, [11:8] picture priority
  localparam int WORD_W = 12;

  localparam logic [3:0] PRIO_CTRL_LIMIT = 4'd3;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_CHUNK = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [1:0] MODE_ERASE = 2'd1;
  localparam logic [1:0] MODE_ADD   = 2'd2;

  typedef enum logic [2:0] {
    REG_POS_X     = 3'd0,
    REG_POS_Y     = 3'd1,
    REG_CEL_W     = 3'd2,
    REG_CEL_H     = 3'd3,
    REG_TRANS_MIR = 3'd4,
    REG_LOOP      = 3'd5,
    REG_DRAW_PRIO = 3'd6,
    REG_MODE      = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PIX   = 5'b00010,
    ST_CHK   = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

endpackage

/* sv/rle_sprite_priority_blitter_core.sv */
// Run-length sprite cel blitter with priority planes.
// Channels: in_* request stream, out_* pixel write stream, cfg_* register writes.
// in_tuser = kind (2b). in_tdata from bit 0: chunk_byte 8, load_x 8, load_y 8,
//   load_color 4, load_priority 4. out_tdata from bit 0: pixel_x 8, pixel_y 8,
//   pixel_color 4, pixel_priority 4; out_tlast marks the last write of a request.
// Start, load, row-end, transparent and ignored chunk requests give no
// output. A coloured chunk is worked pixel by pixel: an off-screen pixel is
// skipped, an on-screen one is read from the plane memory, checked against
// the priority planes (scanning down past control rows in the non-erase
// modes) and written unless the priority check rejects it; each written
// pixel is a read-modify-write of the plane memory.
// One request is worked at a time; in_tready is high only between requests.
// Each pixel write is held one step back so the last one can carry tlast.
// A stalled out_tready holds the output register; the sequencer stalls when a
// further write is ready while both the output register and the held write
// are full. Reset (rst_n low, synchronous) clears config registers, state,
// cursor, row and valid flags but not the planes, undefined until loaded.
// cfg writes are accepted every cycle and must be issued while idle.
// Depends on rspb_pkg, rspb_plane_ram and the assertion macro header.
`include "rle_sprite_priority_blitter_core_assert.svh"
module rle_sprite_priority_blitter_core #(
  parameter int SCREEN_WIDTH  = rspb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = rspb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // chunk_byte, load_x, load_y, load_color, load_priority
  input  logic [1:0]  in_tuser,  // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // pixel_x, pixel_y, pixel_color, pixel_priority
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] W_A = ADDR_W'(SCREEN_WIDTH);
  localparam logic [8:0] W_9 = 9'(SCREEN_WIDTH);
  localparam logic [8:0] H_9 = 9'(SCREEN_HEIGHT);
  localparam logic [7:0] H_LAST = 8'(SCREEN_HEIGHT - 1);

  // config registers
  logic [7:0] pos_x_r, pos_y_r, cel_w_r, cel_h_r, tam_r, loop_r;
  logic [3:0] draw_prio_r;
  logic [1:0] mode_r;

  rspb_pkg::state_t state_r;
  logic [7:0] cursor_r, row_r, sy_r, scan_y_r;
  logic [3:0] cnt_r, color_r;
  logic [ADDR_W-1:0] a_r, scan_addr_r;
  logic [rspb_pkg::WORD_W-1:0] orig_r;
  logic first_r;
  logic [3:0] res_c_r, res_p_r;
  logic       pend_valid_r;
  logic [23:0] pend_data_r;
  logic        out_valid_r, out_last_r;
  logic [23:0] out_data_r;

  // request fields
  logic [1:0] kind;
  logic [7:0] chunk, lx, ly;
  logic [3:0] lcol, lprio;
  assign kind  = in_tuser;
  assign chunk = in_tdata[7:0];
  assign lx    = in_tdata[15:8];
  assign ly    = in_tdata[23:16];
  assign lcol  = in_tdata[27:24];
  assign lprio = in_tdata[31:28];

  logic       mirrored;
  logic [7:0] row_start, sy_calc;
  assign mirrored  = (tam_r[7:4] != 4'd0) && (loop_r != {5'd0, tam_r[6:4]});
  assign row_start = mirrored ? (pos_x_r + cel_w_r - 8'd1) : pos_x_r;
  assign sy_calc   = pos_y_r - (cel_h_r - 8'd1) + row_r;

  logic accept, erase_m, add_m, out_free, out_load;
  assign in_tready = (state_r == rspb_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign erase_m   = (mode_r == rspb_pkg::MODE_ERASE);
  assign add_m     = (mode_r == rspb_pkg::MODE_ADD);
  assign out_free  = !out_valid_r || out_tready;
  // held write moves to the output register
  assign out_load  = pend_valid_r && out_free &&
                     (state_r == rspb_pkg::ST_EMIT || state_r == rspb_pkg::ST_FLUSH);

  logic on_screen;
  assign on_screen = ({1'b0, cursor_r} < W_9) && ({1'b0, sy_r} < H_9);

  logic [ADDR_W-1:0] pix_addr, load_addr;
  assign pix_addr  = ADDR_W'(sy_r) * W_A + ADDR_W'(cursor_r);
  assign load_addr = ADDR_W'(ly) * W_A + ADDR_W'(lx);

  logic [7:0] cursor_step;
  assign cursor_step = mirrored ? (cursor_r - 8'd1) : (cursor_r + 8'd1);

  // memory port
  logic                        ram_we, ram_re;
  logic [ADDR_W-1:0]           ram_waddr, ram_raddr;
  logic [rspb_pkg::WORD_W-1:0] ram_wdata, ram_q;

  rspb_plane_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // priority check on the word just read
  logic [rspb_pkg::WORD_W-1:0] word_orig;
  logic [3:0] bg_p, new_pic_p;
  logic       p_final, draw_ok;
  assign word_orig = first_r ? ram_q : orig_r;
  assign bg_p      = add_m ? ram_q[11:8] : ram_q[3:0];
  assign p_final   = (bg_p >= rspb_pkg::PRIO_CTRL_LIMIT) || (scan_y_r == H_LAST);
  assign draw_ok   = (bg_p >= rspb_pkg::PRIO_CTRL_LIMIT) ? (draw_prio_r >= bg_p) : 1'b1;
  assign new_pic_p = (word_orig[11:8] >= rspb_pkg::PRIO_CTRL_LIMIT) ? draw_prio_r
                                                                     : word_orig[11:8];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_r;
    ram_wdata = word_orig;
    ram_re    = 1'b0;
    ram_raddr = pix_addr;
    unique case (state_r)
      rspb_pkg::ST_IDLE: begin
        if (accept && kind == rspb_pkg::KIND_LOAD && {1'b0, lx} < W_9 && {1'b0, ly} < H_9) begin
          ram_we    = 1'b1;
          ram_waddr = load_addr;
          ram_wdata = {lprio, lcol, lprio};
        end
      end
      rspb_pkg::ST_PIX: begin
        ram_re = (cnt_r != 4'd0) && on_screen;
      end
      rspb_pkg::ST_CHK: begin
        if (erase_m) begin
          ram_we    = 1'b1;
          ram_wdata = {word_orig[11:4], word_orig[11:8]};
        end else if (p_final) begin
          ram_we    = draw_ok;
          ram_wdata = add_m ? {new_pic_p, color_r, draw_prio_r}
                            : {word_orig[11:4], draw_prio_r};
        end else begin
          ram_re    = 1'b1;
          ram_raddr = scan_addr_r + W_A;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0; pos_y_r <= '0; cel_w_r <= '0; cel_h_r <= '0;
      tam_r <= '0; loop_r <= '0; draw_prio_r <= '0; mode_r <= '0;
    end else if (cfg_valid) begin
      unique case (rspb_pkg::reg_idx_t'(cfg_index))
        rspb_pkg::REG_POS_X:     pos_x_r     <= cfg_data;
        rspb_pkg::REG_POS_Y:     pos_y_r     <= cfg_data;
        rspb_pkg::REG_CEL_W:     cel_w_r     <= cfg_data;
        rspb_pkg::REG_CEL_H:     cel_h_r     <= cfg_data;
        rspb_pkg::REG_TRANS_MIR: tam_r       <= cfg_data;
        rspb_pkg::REG_LOOP:      loop_r      <= cfg_data;
        rspb_pkg::REG_DRAW_PRIO: draw_prio_r <= cfg_data[3:0];
        rspb_pkg::REG_MODE:      mode_r      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      out_data_r  <= pend_data_r;
      out_last_r  <= (state_r == rspb_pkg::ST_FLUSH);
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rspb_pkg::ST_IDLE;
      cursor_r     <= '0;
      row_r        <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      first_r      <= 1'b0;
    end else begin
      unique case (state_r)
        rspb_pkg::ST_IDLE: begin
          if (accept) begin
            case (kind)
              rspb_pkg::KIND_START: begin
                row_r    <= '0;
                cursor_r <= row_start;
              end
              rspb_pkg::KIND_CHUNK: begin
                if (row_r < cel_h_r) begin
                  if (chunk == 8'd0) begin
                    row_r    <= row_r + 8'd1;
                    cursor_r <= row_start;
                  end else if (chunk[7:4] == tam_r[3:0]) begin
                    cursor_r <= mirrored ? (cursor_r - {4'd0, chunk[3:0]})
                                         : (cursor_r + {4'd0, chunk[3:0]});
                  end else begin
                    color_r <= chunk[7:4];
                    cnt_r   <= chunk[3:0];
                    sy_r    <= sy_calc;
                    state_r <= rspb_pkg::ST_PIX;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        rspb_pkg::ST_PIX: begin
          if (cnt_r == 4'd0) begin
            state_r <= rspb_pkg::ST_FLUSH;
          end else if (on_screen) begin
            a_r         <= pix_addr;
            scan_addr_r <= pix_addr;
            scan_y_r    <= sy_r;
            first_r     <= 1'b1;
            state_r     <= rspb_pkg::ST_CHK;
          end else begin
            cursor_r <= cursor_step;
            cnt_r    <= cnt_r - 4'd1;
          end
        end
        rspb_pkg::ST_CHK: begin
          orig_r  <= word_orig;
          first_r <= 1'b0;
          if (erase_m) begin
            res_c_r <= word_orig[7:4];
            res_p_r <= word_orig[11:8];
            state_r <= rspb_pkg::ST_EMIT;
          end else if (p_final) begin
            if (draw_ok) begin
              res_c_r <= color_r;
              res_p_r <= draw_prio_r;
              state_r <= rspb_pkg::ST_EMIT;
            end else begin
              cursor_r <= cursor_step;
              cnt_r    <= cnt_r - 4'd1;
              state_r  <= rspb_pkg::ST_PIX;
            end
          end else begin
            scan_addr_r <= scan_addr_r + W_A;
            scan_y_r    <= scan_y_r + 8'd1;
          end
        end
        rspb_pkg::ST_EMIT: begin
          if (!pend_valid_r || out_free) begin
            pend_valid_r <= 1'b1;
            pend_data_r  <= {res_p_r, res_c_r, sy_r, cursor_r};
            cursor_r     <= cursor_step;
            cnt_r        <= cnt_r - 4'd1;
            state_r      <= rspb_pkg::ST_PIX;
          end
        end
        rspb_pkg::ST_FLUSH: begin
          if (!pend_valid_r) begin
            state_r <= rspb_pkg::ST_IDLE;
          end else if (out_free) begin
            pend_valid_r <= 1'b0;
            state_r      <= rspb_pkg::ST_IDLE;
          end
        end
        default: state_r <= rspb_pkg::ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `RSPB_ASSERT(a_no_pend_idle, (state_r == rspb_pkg::ST_IDLE) |-> !pend_valid_r, "write held while idle")
  `RSPB_ASSERT(a_we_source, ram_we |-> (state_r == rspb_pkg::ST_CHK || accept), "stray plane write")
  `RSPB_ASSERT(a_scan_on_screen, (state_r == rspb_pkg::ST_CHK) |-> ({1'b0, scan_y_r} < H_9), "scan left screen")
  `RSPB_ASSERT(a_cnt_live, (state_r == rspb_pkg::ST_CHK || state_r == rspb_pkg::ST_EMIT) |-> (cnt_r != 4'd0), "pixel count underrun")

endmodule

/* sv/rspb_plane_ram.sv */
// Combined plane memory: one write port, one registered read port.
// Depends on rspb_pkg for the word width.
module rspb_plane_ram #(
  parameter int DEPTH  = rspb_pkg::SCREEN_WIDTH_DEF * rspb_pkg::SCREEN_HEIGHT_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [rspb_pkg::WORD_W-1:0] wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [rspb_pkg::WORD_W-1:0] rdata
);

  logic [rspb_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
